// File: design/sph_interface_curvature_assert.svh
// assertion macros for the curvature block
`ifndef SPH_INTERFACE_CURVATURE_ASSERT_SVH
`define SPH_INTERFACE_CURVATURE_ASSERT_SVH
`ifndef SYNTHESIS
`define SIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SIC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SIC_ASSERT(lbl, prop, msg)
`define SIC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/sic_pkg.sv
// shared types, constants and helper functions of the curvature block
package sic_pkg;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned ACCUM_WIDTH   = 48;
  localparam int unsigned RADIUS_W      = 31;
  localparam int unsigned VOL_W         = 31;
  localparam int unsigned POS_W         = 32;
  localparam int unsigned Q_W           = FRACTION_BITS + 2;
  localparam int unsigned DVD_W         = 64 + FRACTION_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DVD_W + 1);
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 31;

  localparam logic [31:0] SELF3_Q32 = 32'd342672697;
  localparam logic [31:0] SELF2_Q32 = 32'd759516973;
  localparam logic [31:0] KW3_Q32   = 32'd11424489;
  localparam logic [31:0] KD3_Q32   = 32'd57122446;
  localparam logic [31:0] KW2_Q32   = 32'd20020740;
  localparam logic [31:0] KD2_Q32   = 32'd100103701;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);
  localparam logic [63:0] INT64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] CAP32_POS = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] CAP32_NEG = 64'h0000_0000_8000_0000;
  localparam logic signed [64:0] ACC_MAX = (65'sd1 <<< (ACCUM_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] ACC_MIN = -ACC_MAX - 65'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPORT_RADIUS = 1'b0,
    CFG_THREE_DIM      = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_FRAC,
    SH_32
  } mul_sh_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IH,
    ST_FIRST,
    ST_SELF_END,
    ST_NB,
    ST_RSQ_X,
    ST_RSQ_Y,
    ST_RSQ_Z,
    ST_CC,
    ST_SQRT,
    ST_Q,
    ST_TERM,
    ST_POW2,
    ST_POW4,
    ST_POW5,
    ST_WF_SET,
    ST_WFD_SET,
    ST_SC_K,
    ST_SC_H,
    ST_DOT_X,
    ST_DOT_Y,
    ST_DOT_Z,
    ST_G1,
    ST_G2,
    ST_GDIV,
    ST_WT,
    ST_LAST,
    ST_FDIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                    first_of_particle;
    logic                    last_of_particle;
    logic                    particle_marked;
    logic                    neighbor_marked;
    logic [VOL_W-1:0]        self_volume;
    logic [VOL_W-1:0]        neighbor_volume;
    logic signed [POS_W-1:0] offset_x;
    logic signed [POS_W-1:0] offset_y;
    logic signed [POS_W-1:0] offset_z;
    logic signed [POS_W-1:0] normal_diff_x;
    logic signed [POS_W-1:0] normal_diff_y;
    logic signed [POS_W-1:0] normal_diff_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curvature_value;
    logic               zero_normalizer;
  } out_item_t;

  function automatic logic [63:0] magn64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sext32(input logic [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? INT64_MIN : INT64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [ACCUM_WIDTH-1:0] sat_acc(
      input logic signed [ACCUM_WIDTH-1:0] a, input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > ACC_MAX) begin
      return ACC_MAX[ACCUM_WIDTH-1:0];
    end
    if (s < ACC_MIN) begin
      return ACC_MIN[ACCUM_WIDTH-1:0];
    end
    return s[ACCUM_WIDTH-1:0];
  endfunction

endpackage

// File: design/sic_channels.sv
// request and result channels of the curvature block
interface sic_in_if;
  logic               valid;
  logic               ready;
  sic_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sic_out_if;
  logic               valid;
  logic               ready;
  sic_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/sic_mul.sv
// shared saturating multiplier, four 32x32 partial products accumulated in turn
module sic_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  input  sic_pkg::mul_sh_e    sh_i,
  output logic                done_o,
  output logic signed [63:0]  res_o
);

  logic [63:0]        ma_q, mb_q;
  logic               neg_q;
  sic_pkg::mul_sh_e   sh_q;
  logic [127:0]       p_q;
  logic [2:0]         step_q;
  logic               busy_q, done_q;
  logic signed [63:0] res_q;
  logic [31:0]        opa, opb;
  logic [63:0]        part;
  logic [127:0]       part_w, shifted;
  logic               over;
  logic signed [63:0] fin;

  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin
        opa = ma_q[31:0];
        opb = mb_q[31:0];
      end
      2'd1: begin
        opa = ma_q[31:0];
        opb = mb_q[63:32];
      end
      2'd2: begin
        opa = ma_q[63:32];
        opb = mb_q[31:0];
      end
      default: begin
        opa = ma_q[63:32];
        opb = mb_q[63:32];
      end
    endcase
    part = 64'(opa) * 64'(opb);
    unique case (step_q[1:0])
      2'd0:    part_w = 128'(part);
      2'd3:    part_w = 128'(part) << 64;
      default: part_w = 128'(part) << 32;
    endcase
    unique case (sh_q)
      sic_pkg::SH_FRAC: shifted = p_q >> sic_pkg::FRACTION_BITS;
      sic_pkg::SH_32:   shifted = p_q >> 32;
      default:          shifted = p_q;
    endcase
    over = |shifted[127:63];
    if (over) begin
      fin = neg_q ? sic_pkg::INT64_MIN : sic_pkg::INT64_MAX;
    end else begin
      fin = neg_q ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q[2]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= sic_pkg::magn64(a_i);
      mb_q  <= sic_pkg::magn64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      sh_q  <= sh_i;
      p_q   <= '0;
    end else if (busy_q) begin
      if (step_q[2]) begin
        res_q <= fin;
      end else begin
        p_q <= p_q + part_w;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: design/sic_div.sv
// shared restoring divider, one quotient bit per cycle, result capped
module sic_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  input  logic [63:0] cap_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  localparam int unsigned DW = sic_pkg::DVD_W;

  logic [DW-1:0]                   dvd_q, quo_q;
  logic [63:0]                     den_q, cap_q, rem_q, res_q;
  logic [sic_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                            busy_q, done_q;
  logic [64:0]                     rem_sh, rem_sub;
  logic                            ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= sic_pkg::DIV_CNT_W'(DW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - sic_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, {sic_pkg::FRACTION_BITS{1'b0}}};
      den_q <= den_i;
      cap_q <= cap_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        res_q <= (quo_q > DW'(cap_q)) ? cap_q : quo_q[63:0];
      end else begin
        rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
        quo_q <= {quo_q[DW-2:0], ge};
        dvd_q <= {dvd_q[DW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: design/sic_sqrt.sv
// floor square root, one result bit per cycle
module sic_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] src_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [36:0] rem_sh, trial, rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_q, src_q[63:62]};
    trial   = {3'b000, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    ge      = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      src_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rem_q  <= ge ? rem_sub[34:0] : rem_sh[34:0];
      root_q <= {root_q[30:0], ge};
      src_q  <= {src_q[61:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: design/sph_interface_curvature.sv
// top level: sequencer, accumulators and result register of the curvature block
//
// in_ch takes one neighbour request per item (valid/ready, accepted when both
// are high); first/last flags frame a particle. out_ch gives one result per
// item carrying the last flag. The configuration port (cfg_we_i, cfg_idx_i,
// cfg_data_i) writes the support radius and the 2d/3d select; the user must
// write it only while idle, the block itself does not enforce this. Each item
// runs through a sequencer that drives one shared multiplier, one restoring
// divider and one square-root unit; in_ch is not ready meanwhile. The block
// takes one item at a time.
// The result sits in an output register, so a stalled receiver does not hold
// the next item; only a second result waits until the first is taken.
// Reset clears the sums, the active flag and the output valid flag, and sets
// the radius to 1.0 and the 3d select.
`include "sph_interface_curvature_assert.svh"

module sph_interface_curvature (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sic_in_if.sink                             in_ch,
  sic_out_if.source                          out_ch,
  input  logic                               cfg_we_i,
  input  logic [sic_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sic_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned F   = sic_pkg::FRACTION_BITS;
  localparam int unsigned QW  = sic_pkg::Q_W;
  localparam int unsigned AW  = sic_pkg::ACCUM_WIDTH;

  sic_pkg::state_e   state_q, state_d, ret_q, ret_d;
  sic_pkg::in_item_t item_q;
  sic_pkg::out_item_t out_data_q, out_data_d;
  logic [sic_pkg::RADIUS_W-1:0] radius_q;
  logic                td_q;
  logic [63:0]         ih_q, ih_d, rsq_q, rsq_d;
  logic [31:0]         r_q, r_d, kc_q, kc_d;
  logic [QW-1:0]       q_q, q_d, x_q, x_d, kone;
  logic [1:0]          t_q, t_d;
  logic [2:0]          cnt_q, cnt_d;
  logic signed [63:0]  v_q, v_d, w_q, w_d, dw_q, dw_d, wf_q, wf_d, dot_q, dot_d;
  logic signed [AW-1:0] cs_q, cs_d, ws_q, ws_d;
  logic                active_q, active_d, issued_q, issued_d;
  logic signed [31:0]  res_val_q, res_val_d;
  logic                res_flag_q, res_flag_d, out_valid_q, out_valid_d;
  logic                in_acc, fin_neg, emit_go;

  logic                mul_start, mul_done;
  logic signed [63:0]  mul_a, mul_b, mul_res;
  sic_pkg::mul_sh_e    mul_sh;
  logic                div_start, div_done;
  logic [63:0]         div_num, div_den, div_cap, div_res;
  logic                sqrt_start, sqrt_done;
  logic [63:0]         sqrt_in;
  logic [31:0]         sqrt_res;
  logic signed [63:0]  g_val;

  sic_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b), .sh_i(mul_sh),
    .done_o(mul_done), .res_o(mul_res)
  );

  sic_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .cap_i(div_cap), .done_o(div_done), .res_o(div_res)
  );

  sic_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .val_i(sqrt_in), .done_o(sqrt_done),
    .root_o(sqrt_res)
  );

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == sic_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;
  assign kone         = {(2'd3 - t_q), {F{1'b0}}};
  assign fin_neg      = cs_q[AW-1] ^ ws_q[AW-1];
  assign emit_go      = !out_valid_q || out_ch.ready;
  assign g_val        = v_q[63] ? -$signed(div_res) : $signed(div_res);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sic_pkg::ST_IDLE:     if (in_acc) state_d = sic_pkg::ST_IH;
      sic_pkg::ST_IH:       if (div_done) state_d = sic_pkg::ST_FIRST;
      sic_pkg::ST_FIRST: begin
        state_d = (item_q.first_of_particle && item_q.particle_marked) ?
                  sic_pkg::ST_SC_K : sic_pkg::ST_NB;
      end
      sic_pkg::ST_SELF_END: state_d = sic_pkg::ST_NB;
      sic_pkg::ST_NB: begin
        state_d = (active_q && item_q.neighbor_marked) ? sic_pkg::ST_RSQ_X : sic_pkg::ST_LAST;
      end
      sic_pkg::ST_RSQ_X:    if (mul_done) state_d = sic_pkg::ST_RSQ_Y;
      sic_pkg::ST_RSQ_Y:    if (mul_done) state_d = sic_pkg::ST_RSQ_Z;
      sic_pkg::ST_RSQ_Z:    if (mul_done) state_d = sic_pkg::ST_CC;
      sic_pkg::ST_CC: begin
        if (mul_done) begin
          state_d = (rsq_q != '0 && rsq_q < $unsigned(mul_res)) ?
                    sic_pkg::ST_SQRT : sic_pkg::ST_LAST;
        end
      end
      sic_pkg::ST_SQRT:     if (sqrt_done) state_d = sic_pkg::ST_Q;
      sic_pkg::ST_Q:        if (div_done) state_d = sic_pkg::ST_TERM;
      sic_pkg::ST_TERM:     state_d = (q_q < kone) ? sic_pkg::ST_POW2 : sic_pkg::ST_WF_SET;
      sic_pkg::ST_POW2:     if (mul_done) state_d = sic_pkg::ST_POW4;
      sic_pkg::ST_POW4:     if (mul_done) state_d = sic_pkg::ST_POW5;
      sic_pkg::ST_POW5:     if (mul_done) state_d = sic_pkg::ST_TERM;
      sic_pkg::ST_WF_SET:   state_d = sic_pkg::ST_SC_K;
      sic_pkg::ST_WFD_SET:  state_d = sic_pkg::ST_SC_K;
      sic_pkg::ST_SC_K:     if (mul_done) state_d = sic_pkg::ST_SC_H;
      sic_pkg::ST_SC_H:     if (mul_done && cnt_q == 3'd1) state_d = ret_q;
      sic_pkg::ST_DOT_X:    if (mul_done) state_d = sic_pkg::ST_DOT_Y;
      sic_pkg::ST_DOT_Y:    if (mul_done) state_d = sic_pkg::ST_DOT_Z;
      sic_pkg::ST_DOT_Z:    if (mul_done) state_d = sic_pkg::ST_G1;
      sic_pkg::ST_G1:       if (mul_done) state_d = sic_pkg::ST_G2;
      sic_pkg::ST_G2:       if (mul_done) state_d = sic_pkg::ST_GDIV;
      sic_pkg::ST_GDIV:     if (div_done) state_d = sic_pkg::ST_WT;
      sic_pkg::ST_WT:       if (mul_done) state_d = sic_pkg::ST_LAST;
      sic_pkg::ST_LAST: begin
        if (!item_q.last_of_particle) begin
          state_d = sic_pkg::ST_IDLE;
        end else if (active_q && ws_q != '0) begin
          state_d = sic_pkg::ST_FDIV;
        end else begin
          state_d = sic_pkg::ST_EMIT;
        end
      end
      sic_pkg::ST_FDIV:     if (div_done) state_d = sic_pkg::ST_EMIT;
      sic_pkg::ST_EMIT:     if (emit_go) state_d = sic_pkg::ST_IDLE;
      default:              state_d = sic_pkg::ST_IDLE;
    endcase
  end

  // unit control and datapath
  always_comb begin
    ret_d = ret_q;   ih_d = ih_q;   rsq_d = rsq_q; r_d = r_q;   kc_d = kc_q;
    q_d = q_q;       x_d = x_q;     t_d = t_q;     cnt_d = cnt_q;
    v_d = v_q;       w_d = w_q;     dw_d = dw_q;   wf_d = wf_q; dot_d = dot_q;
    cs_d = cs_q;     ws_d = ws_q;   active_d = active_q;
    res_val_d = res_val_q;          res_flag_d = res_flag_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    mul_start = 1'b0;  mul_a = '0;  mul_b = '0;  mul_sh = sic_pkg::SH_FRAC;
    div_start = 1'b0;  div_num = '0; div_den = '0; div_cap = sic_pkg::INT64_MAX;
    sqrt_start = 1'b0; sqrt_in = rsq_q;
    unique case (state_q)
      sic_pkg::ST_IH: begin
        div_start = !issued_q;
        div_num   = 64'(3) << F;
        div_den   = 64'(radius_q);
        if (div_done) ih_d = div_res;
      end
      sic_pkg::ST_FIRST: begin
        if (item_q.first_of_particle) begin
          cs_d     = '0;
          ws_d     = '0;
          active_d = item_q.particle_marked;
          v_d      = 64'(item_q.self_volume);
          kc_d     = td_q ? sic_pkg::SELF3_Q32 : sic_pkg::SELF2_Q32;
          cnt_d    = td_q ? 3'd3 : 3'd2;
          ret_d    = sic_pkg::ST_SELF_END;
        end
      end
      sic_pkg::ST_SELF_END: ws_d = sic_pkg::sat_acc('0, v_q);
      sic_pkg::ST_RSQ_X, sic_pkg::ST_RSQ_Y, sic_pkg::ST_RSQ_Z: begin
        mul_start = !issued_q;
        mul_sh    = sic_pkg::SH_NONE;
        if (state_q == sic_pkg::ST_RSQ_X) begin
          mul_a = sic_pkg::sext32(item_q.offset_x);
        end else if (state_q == sic_pkg::ST_RSQ_Y) begin
          mul_a = sic_pkg::sext32(item_q.offset_y);
        end else begin
          mul_a = sic_pkg::sext32(item_q.offset_z);
        end
        mul_b = mul_a;
        if (mul_done) begin
          rsq_d = (state_q == sic_pkg::ST_RSQ_X) ? $unsigned(mul_res) :
                  rsq_q + $unsigned(mul_res);
        end
      end
      sic_pkg::ST_CC: begin
        mul_start = !issued_q;
        mul_sh    = sic_pkg::SH_NONE;
        mul_a     = 64'(radius_q);
        mul_b     = 64'(radius_q);
      end
      sic_pkg::ST_SQRT: begin
        sqrt_start = !issued_q;
        if (sqrt_done) r_d = sqrt_res;
      end
      sic_pkg::ST_Q: begin
        div_start = !issued_q;
        div_num   = (64'(r_q) << 1) + 64'(r_q);
        div_den   = 64'(radius_q);
        if (div_done) begin
          q_d  = div_res[QW-1:0];
          w_d  = '0;
          dw_d = '0;
          t_d  = '0;
        end
      end
      sic_pkg::ST_TERM: x_d = kone - q_q;
      sic_pkg::ST_POW2: begin
        mul_start = !issued_q;
        mul_a     = 64'(x_q);
        mul_b     = 64'(x_q);
        if (mul_done) v_d = mul_res;
      end
      sic_pkg::ST_POW4: begin
        mul_start = !issued_q;
        mul_a     = v_q;
        mul_b     = v_q;
        if (mul_done) v_d = mul_res;
      end
      sic_pkg::ST_POW5: begin
        mul_start = !issued_q;
        mul_a     = v_q;
        mul_b     = 64'(x_q);
        if (mul_done) begin
          t_d = t_q + 2'd1;
          unique case (t_q)
            2'd0: begin
              w_d  = w_q + mul_res;
              dw_d = dw_q - v_q;
            end
            2'd1: begin
              w_d  = w_q - ((mul_res <<< 2) + (mul_res <<< 1));
              dw_d = dw_q + ((v_q <<< 2) + (v_q <<< 1));
            end
            2'd2: begin
              w_d  = w_q + ((mul_res <<< 4) - mul_res);
              dw_d = dw_q - ((v_q <<< 4) - v_q);
            end
            default: ;
          endcase
        end
      end
      sic_pkg::ST_WF_SET: begin
        v_d   = w_q;
        kc_d  = td_q ? sic_pkg::KW3_Q32 : sic_pkg::KW2_Q32;
        cnt_d = td_q ? 3'd3 : 3'd2;
        ret_d = sic_pkg::ST_WFD_SET;
      end
      sic_pkg::ST_WFD_SET: begin
        wf_d  = v_q;
        v_d   = dw_q;
        kc_d  = td_q ? sic_pkg::KD3_Q32 : sic_pkg::KD2_Q32;
        cnt_d = td_q ? 3'd4 : 3'd3;
        ret_d = sic_pkg::ST_DOT_X;
      end
      sic_pkg::ST_SC_K: begin
        mul_start = !issued_q;
        mul_a     = v_q;
        mul_b     = 64'(kc_q);
        mul_sh    = sic_pkg::SH_32;
        if (mul_done) v_d = mul_res;
      end
      sic_pkg::ST_SC_H: begin
        mul_start = !issued_q;
        mul_a     = v_q;
        mul_b     = ih_q;
        if (mul_done) begin
          v_d   = mul_res;
          cnt_d = cnt_q - 3'd1;
        end
      end
      sic_pkg::ST_DOT_X, sic_pkg::ST_DOT_Y, sic_pkg::ST_DOT_Z: begin
        mul_start = !issued_q;
        if (state_q == sic_pkg::ST_DOT_X) begin
          mul_a = sic_pkg::sext32(item_q.normal_diff_x);
          mul_b = sic_pkg::sext32(item_q.offset_x);
        end else if (state_q == sic_pkg::ST_DOT_Y) begin
          mul_a = sic_pkg::sext32(item_q.normal_diff_y);
          mul_b = sic_pkg::sext32(item_q.offset_y);
        end else begin
          mul_a = sic_pkg::sext32(item_q.normal_diff_z);
          mul_b = sic_pkg::sext32(item_q.offset_z);
        end
        if (mul_done) begin
          dot_d = (state_q == sic_pkg::ST_DOT_X) ? mul_res :
                  sic_pkg::sat_add64(dot_q, mul_res);
        end
      end
      sic_pkg::ST_G1: begin
        mul_start = !issued_q;
        mul_a     = dot_q;
        mul_b     = v_q;
        if (mul_done) v_d = mul_res;
      end
      sic_pkg::ST_G2: begin
        mul_start = !issued_q;
        mul_a     = v_q;
        mul_b     = 64'(item_q.neighbor_volume);
        if (mul_done) v_d = mul_res;
      end
      sic_pkg::ST_GDIV: begin
        div_start = !issued_q;
        div_num   = sic_pkg::magn64(v_q);
        div_den   = 64'(r_q);
        if (div_done) cs_d = sic_pkg::sat_acc(cs_q, g_val);
      end
      sic_pkg::ST_WT: begin
        mul_start = !issued_q;
        mul_a     = wf_q;
        mul_b     = 64'(item_q.neighbor_volume);
        if (mul_done) ws_d = sic_pkg::sat_acc(ws_q, mul_res);
      end
      sic_pkg::ST_LAST: begin
        res_val_d  = '0;
        res_flag_d = active_q && (ws_q == '0);
      end
      sic_pkg::ST_FDIV: begin
        div_start = !issued_q;
        div_num   = sic_pkg::magn64(64'(cs_q));
        div_den   = sic_pkg::magn64(64'(ws_q));
        div_cap   = fin_neg ? sic_pkg::CAP32_NEG : sic_pkg::CAP32_POS;
        if (div_done) begin
          res_val_d  = fin_neg ? 32'(-div_res) : 32'(div_res);
          res_flag_d = 1'b0;
        end
      end
      sic_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_d                = 1'b1;
          out_data_d.curvature_value = res_val_q;
          out_data_d.zero_normalizer = res_flag_q;
          active_d                   = 1'b0;
        end
      end
      default: ;
    endcase
    issued_d = issued_q;
    if (mul_start || div_start || sqrt_start) issued_d = 1'b1;
    if (mul_done || div_done || sqrt_done) issued_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sic_pkg::ST_IDLE;
      radius_q    <= sic_pkg::RADIUS_RESET;
      td_q        <= 1'b1;
      cs_q        <= '0;
      ws_q        <= '0;
      active_q    <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      ws_q        <= ws_d;
      active_q    <= active_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (sic_pkg::cfg_idx_e'(cfg_idx_i))
          sic_pkg::CFG_SUPPORT_RADIUS: radius_q <= cfg_data_i;
          sic_pkg::CFG_THREE_DIM:      td_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_ch.data;
    ret_q      <= ret_d;
    ih_q       <= ih_d;
    rsq_q      <= rsq_d;
    r_q        <= r_d;
    kc_q       <= kc_d;
    q_q        <= q_d;
    x_q        <= x_d;
    t_q        <= t_d;
    cnt_q      <= cnt_d;
    v_q        <= v_d;
    w_q        <= w_d;
    dw_q       <= dw_d;
    wf_q       <= wf_d;
    dot_q      <= dot_d;
    res_val_q  <= res_val_d;
    res_flag_q <= res_flag_d;
    out_data_q <= out_data_d;
  end

  `SIC_ASSERT(a_emit_only, $rose(out_valid_q) |-> $past(state_q) == sic_pkg::ST_EMIT, "result loaded outside emit")
  `SIC_ASSERT(a_one_unit, $onehot0({mul_start, div_start, sqrt_start}), "two units started at once")
  `SIC_ASSERT(a_zero_flag, out_valid_q && out_data_q.zero_normalizer |-> out_data_q.curvature_value == '0, "zero normaliser with nonzero value")
  `SIC_ASSERT_NEVER(a_ready_busy, in_ch.ready && issued_q, "input ready while a unit is busy")

endmodule

// File: test/curvature_checker.sv
// curvature checker: watches the request and result channels, predicts each result and compares
`timescale 1ns / 1ps

module curvature_checker
  import sic_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sic_in_if                     in_ch,
  sic_out_if                    out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

  logic [RADIUS_W-1:0]          radius;
  logic                         td;
  logic signed [ACCUM_WIDTH-1:0] curv_acc;
  logic signed [ACCUM_WIDTH-1:0] norm_acc;
  logic                         active;
  out_item_t                    curvature_q[$];
  int                           errors;

  assign errors_o  = errors;
  assign pending_o = curvature_q.size();

  function automatic logic [63:0] mag(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint prod_shift(longint a, longint b, int sh);
    logic [127:0] p;
    logic         neg;
    neg = (a < 0) != (b < 0);
    p = (128'(mag(a)) * 128'(mag(b))) >> sh;
    if (p > 128'(INT64_MAX)) return neg ? longint'(INT64_MIN) : longint'(INT64_MAX);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] m, logic [63:0] d, logic [63:0] cap);
    logic [DVD_W-1:0] q;
    q = (DVD_W'(m) << FRACTION_BITS) / DVD_W'(d);
    return q > DVD_W'(cap) ? cap : q[63:0];
  endfunction

  function automatic longint signed_div(longint num, longint den, logic [63:0] cp,
                                        logic [63:0] cn);
    logic        neg;
    logic [63:0] q;
    neg = (num < 0) != (den < 0);
    q = frac_div(mag(num), mag(den), neg ? cn : cp);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint add_clip(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? longint'(INT64_MIN) : longint'(INT64_MAX);
    return longint'(s[63:0]);
  endfunction

  function automatic logic signed [ACCUM_WIDTH-1:0] acc_add(
      logic signed [ACCUM_WIDTH-1:0] a, longint b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    if (s > 66'(ACC_MAX)) return ACC_MAX[ACCUM_WIDTH-1:0];
    if (s < 66'(ACC_MIN)) return ACC_MIN[ACCUM_WIDTH-1:0];
    return s[ACCUM_WIDTH-1:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bm;
    res = 0;
    bm = 64'd1 << 62;
    while (bm > v) bm = bm >> 2;
    while (bm != 0) begin
      if (v >= res + bm) begin
        v = v - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  function automatic void pow45(logic [63:0] x, output longint p4, output longint p5);
    logic [63:0] p2;
    logic [63:0] f4;
    p2 = (x * x) >> FRACTION_BITS;
    f4 = (p2 * p2) >> FRACTION_BITS;
    p4 = longint'(f4);
    p5 = longint'((f4 * x) >> FRACTION_BITS);
  endfunction

  function automatic longint kernel_scale(longint v, logic [31:0] k, longint ih, int n);
    int i;
    v = prod_shift(v, longint'({32'b0, k}), 32);
    for (i = 0; i < n; i++) v = prod_shift(v, ih, FRACTION_BITS);
    return v;
  endfunction

  task automatic absorb_pair(in_item_t it);
    logic [63:0] cut, rsq, r, q;
    longint      ih, dx, dy, dz, vol, a4, a5, b4, b5, c4, c5, w, dw, wf, wfd, dot, g, val;
    logic        flag;
    cut = 64'(radius);
    ih  = cut != 0 ? longint'((64'd3 << (2 * FRACTION_BITS)) / cut) : longint'(INT64_MAX);
    if (it.first_of_particle) begin
      curv_acc = '0;
      norm_acc = '0;
      active   = it.particle_marked;
      if (active) begin
        norm_acc = acc_add('0, kernel_scale(longint'(it.self_volume),
                                            td ? SELF3_Q32 : SELF2_Q32, ih, td ? 3 : 2));
      end
    end
    if (active && it.neighbor_marked) begin
      dx  = longint'(it.offset_x);
      dy  = longint'(it.offset_y);
      dz  = longint'(it.offset_z);
      rsq = mag(dx) * mag(dx) + mag(dy) * mag(dy) + mag(dz) * mag(dz);
      if (rsq != 0 && rsq < cut * cut) begin
        r   = root_floor(rsq);
        q   = ((64'd3 * r) << FRACTION_BITS) / cut;
        vol = longint'(it.neighbor_volume);
        pow45(3 * ONE - q, a4, a5);
        w  = a5;
        dw = -a4;
        if (q < 2 * ONE) begin
          pow45(2 * ONE - q, b4, b5);
          w  = w - 6 * b5;
          dw = dw + 6 * b4;
          if (q < ONE) begin
            pow45(ONE - q, c4, c5);
            w  = w + 15 * c5;
            dw = dw - 15 * c4;
          end
        end
        wf  = kernel_scale(w, td ? KW3_Q32 : KW2_Q32, ih, td ? 3 : 2);
        wfd = kernel_scale(dw, td ? KD3_Q32 : KD2_Q32, ih, td ? 4 : 3);
        dot = prod_shift(longint'(it.normal_diff_x), dx, FRACTION_BITS);
        dot = add_clip(dot, prod_shift(longint'(it.normal_diff_y), dy, FRACTION_BITS));
        dot = add_clip(dot, prod_shift(longint'(it.normal_diff_z), dz, FRACTION_BITS));
        g = prod_shift(dot, wfd, FRACTION_BITS);
        g = prod_shift(g, vol, FRACTION_BITS);
        g = signed_div(g, longint'(r), INT64_MAX, INT64_MAX);
        curv_acc = acc_add(curv_acc, g);
        norm_acc = acc_add(norm_acc, prod_shift(wf, vol, FRACTION_BITS));
      end
    end
    if (it.last_of_particle) begin
      val  = 0;
      flag = 1'b0;
      if (active) begin
        if (norm_acc == 0) flag = 1'b1;
        else val = signed_div(longint'(curv_acc), longint'(norm_acc), CAP32_POS, CAP32_NEG);
      end
      curvature_q.push_back('{curvature_value: val[31:0], zero_normalizer: flag});
      active = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      radius   = RADIUS_RESET;
      td       = 1'b1;
      curv_acc = '0;
      norm_acc = '0;
      active   = 1'b0;
      errors   = 0;
      curvature_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_SUPPORT_RADIUS) radius = cfg_data_i[RADIUS_W-1:0];
        else if (cfg_idx_e'(cfg_idx_i) == CFG_THREE_DIM) td = cfg_data_i[0];
      end
      if (in_ch.valid && in_ch.ready) absorb_pair(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (curvature_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected curvature result %0d/%0b",
                                     out_ch.data.curvature_value, out_ch.data.zero_normalizer);
        end else begin
          exp_r = curvature_q.pop_front();
          if (out_ch.data.curvature_value !== exp_r.curvature_value ||
              out_ch.data.zero_normalizer !== exp_r.zero_normalizer) begin
            if (out_ch.data.curvature_value !== exp_r.curvature_value) errors = errors + 1;
            if (out_ch.data.zero_normalizer !== exp_r.zero_normalizer) errors = errors + 1;
            if (errors <= 10) $display("curvature mismatch: expected %0d/%0b got %0d/%0b",
                                       exp_r.curvature_value, exp_r.zero_normalizer,
                                       out_ch.data.curvature_value,
                                       out_ch.data.zero_normalizer);
          end
        end
      end
    end
  end

endmodule

// File: test/tb.sv
// testbench top: clock, reset, neighbour-pair stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb;
  import sic_pkg::*;

  localparam int DRAIN = 700;
  localparam int LIMIT = 6000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    errors, pending;
  logic                  quiet = 1'b0;
  int unsigned           cycle = 0;
  int unsigned           hold_left = 0;

  sic_in_if  in_ch ();
  sic_out_if out_ch ();

  sph_interface_curvature dut (
    .clk_i, .rst_ni, .in_ch, .out_ch, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  curvature_checker u_checker (
    .clk_i, .rst_ni, .in_ch, .out_ch, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  // receiver, with one long hold-off so the block backs up
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (cycle == 40000) begin
      hold_left    <= 5000;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || $urandom_range(99) >= 18;
    end
  end

  logic [RADIUS_W-1:0] cut = RADIUS_RESET;

  task automatic send(in_item_t it);
    while (!quiet && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(logic [RADIUS_W-1:0] r, logic d3);
    settle();
    set_reg(CFG_SUPPORT_RADIUS, r);
    set_reg(CFG_THREE_DIM, CFG_DATA_W'(d3));
    cut = r;
  endtask

  function automatic in_item_t pair(logic f, logic l, logic pm, logic nm, int sv, int nv,
                                    int dx, int dy, int dz, int nx, int ny, int nz);
    in_item_t it;
    it.first_of_particle = f;
    it.last_of_particle  = l;
    it.particle_marked   = pm;
    it.neighbor_marked   = nm;
    it.self_volume       = sv[30:0];
    it.neighbor_volume   = nv[30:0];
    it.offset_x          = dx;
    it.offset_y          = dy;
    it.offset_z          = dz;
    it.normal_diff_x     = nx;
    it.normal_diff_y     = ny;
    it.normal_diff_z     = nz;
    return it;
  endfunction

  function automatic int rand_offset();
    int unsigned m;
    m = $urandom_range(99);
    if (m < 6) return 0;
    if (m < 80) begin
      m = $urandom_range(0, cut / 2);
      return $urandom_range(1) ? -int'(m) : int'(m);
    end
    return $urandom;
  endfunction

  function automatic int rand_normal();
    return $urandom_range(99) < 80 ? int'($urandom_range(0, 262144)) - 131072 : $urandom;
  endfunction

  function automatic int rand_volume();
    int unsigned m;
    m = $urandom_range(99);
    if (m < 80) return $urandom_range(0, 262144);
    if (m < 90) return 0;
    return $urandom >> 1;
  endfunction

  task automatic random_particle(inout int count);
    int       n, k;
    logic     pm;
    in_item_t it;
    n  = $urandom_range(1, 5);
    pm = $urandom_range(99) < 88;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 5) begin
        it = pair(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        it = pair(k == 0, k == n - 1, pm, $urandom_range(99) < 85, rand_volume(),
                  rand_volume(), rand_offset(), rand_offset(), rand_offset(),
                  rand_normal(), rand_normal(), rand_normal());
        if ($urandom_range(99) < 4) it.first_of_particle = ~it.first_of_particle;
        if ($urandom_range(99) < 4) it.last_of_particle = ~it.last_of_particle;
      end
      send(it);
      count++;
    end
  endtask

  initial begin
    int count, ph;
    logic [RADIUS_W-1:0] radii[7] = '{65536, 196608, 1, 31'h7fffffff, 3276800, 40000,
                                      31'h7fffffff};
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_SUPPORT_RADIUS;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // self term only, in one item
    send(pair(1, 1, 1, 0, 65536, 0, 0, 0, 0, 0, 0, 0));
    // one particle over the inner and outer kernel ranges, zero distance and outside the cutoff
    send(pair(1, 0, 1, 1, 32'h7fffffff, 32'h7fffffff, 10000, 0, 0, 65536, 0, 0));
    send(pair(0, 0, 1, 1, 0, 65536, -16384, 8192, -4096, -65536, 32768, 1000));
    send(pair(0, 0, 1, 1, 0, 65536, 0, 0, 0, 65536, 65536, 65536));
    send(pair(0, 0, 1, 1, 0, 65536, 65536, 0, 0, 65536, 0, 0));
    send(pair(0, 0, 1, 1, 0, 65536, 0, 50000, 0, 0, -65536, 0));
    send(pair(0, 0, 1, 0, 0, 65536, 100, 100, 100, 65536, 0, 0));
    send(pair(0, 1, 1, 1, 0, 0, 2000, -3000, 500, 32'h7fffffff, 32'h80000000,
              32'h7fffffff));
    // unmarked particle
    send(pair(1, 0, 0, 1, 65536, 65536, 1000, 0, 0, 65536, 0, 0));
    send(pair(0, 1, 0, 1, 65536, 65536, 2000, 0, 0, 65536, 0, 0));
    // last without first
    send(pair(0, 1, 1, 1, 65536, 65536, 1000, 0, 0, 65536, 0, 0));
    // zero normaliser
    send(pair(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // extreme offsets and volumes
    send(pair(1, 0, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send(pair(0, 1, 1, 1, 0, 32'h7fffffff, -1, 1, -1, 32'h80000000, 32'h7fffffff, 0));
    // large radius, 2d, extremes at exactly the cutoff distance, so outside it
    reconfigure(31'h7fffffff, 1'b0);
    send(pair(1, 0, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0,
              32'h7fffffff, 0, 0));
    send(pair(0, 1, 1, 1, 0, 32'h7fffffff, 32'h80000001, 0, 0, 32'h7fffffff, 0, 0));
    send(pair(1, 1, 1, 1, 1, 1, 1, 0, 0, 32'h80000000, 0, 0));

    count = 0;
    for (ph = 0; ph < 7; ph++) begin
      reconfigure(radii[ph], ph[0] ? 1'b0 : 1'b1);
      quiet = (ph == 2);
      while (count < (ph + 1) * 250) begin
        random_particle(count);
        if (ph == 4 && count >= 1100 && count < 1106) settle();
      end
    end
    quiet = 1'b0;
    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
